>>> design/hi3d_pkg.sv
// hi3d_pkg: types and fixed constants for the 3d hilbert index pipeline
// no dependencies; imported by hilbert_index_3d

package hi3d_pkg;

    // input coordinate width and internal width with one guard bit
    localparam int COORD_W = 16;
    localparam int INT_W   = COORD_W + 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [INT_W-1:0]   icoord_t;

    // +1.0 in internal units (2^-15)
    localparam icoord_t ONE_Q = icoord_t'(17'sd32768);

    // x,y quadrant codes, value is the number of eighths added
    typedef enum logic [1:0] {
        QUAD_PP = 2'd0,   // x >= 0, y >= 0
        QUAD_PN = 2'd1,   // x >= 0, y < 0
        QUAD_NN = 2'd2,   // x < 0,  y < 0
        QUAD_NP = 2'd3    // x < 0,  y >= 0
    } quad_t;

    // halve-and-double translate: p -> 2p - sgn(p), sgn(0) = +1
    function automatic icoord_t translate(input icoord_t p);
        icoord_t dbl;
        dbl = p <<< 1;
        return (p >= 0) ? icoord_t'(dbl - ONE_Q) : icoord_t'(dbl + ONE_Q);
    endfunction

    // quadrant of the point in the x,y plane
    function automatic quad_t quadrant(input icoord_t x, input icoord_t y);
        quad_t q;
        if (x >= 0)
            q = (y >= 0) ? QUAD_PP : QUAD_PN;
        else
            q = (y < 0) ? QUAD_NN : QUAD_NP;
        return q;
    endfunction

endpackage

>>> design/hilbert_index_3d.sv
// hilbert_index_3d: 3d point to hilbert-style curve position, one level per stage
// depends on hi3d_pkg (types, translate and quadrant helpers)
//
// every level is one register stage of the pipeline; the last stage is the output
// throughput: one item per cycle while the output is not stalled
// a stall on the output holds the whole pipeline, nothing is lost or repeated
// reset: asynchronous, clears the stage valid bits only; no other state

module hilbert_index_3d #(
    parameter int LEVELS = 15
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  hi3d_pkg::coord_t        coord_x,
    input  hi3d_pkg::coord_t        coord_y,
    input  hi3d_pkg::coord_t        coord_z,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [3*LEVELS:0]       curve_index
);
    import hi3d_pkg::*;

    localparam int SUM_W = 3 * LEVELS + 1;

    typedef logic [SUM_W-1:0] sum_t;

    // per-stage registers
    logic    valid_reg [LEVELS];
    icoord_t x_reg     [LEVELS];
    icoord_t y_reg     [LEVELS];
    icoord_t z_reg     [LEVELS];
    sum_t    sum_reg   [LEVELS];
    logic    neg_reg   [LEVELS];

    logic advance;

    // whole pipeline moves unless the output item is held
    assign advance  = !valid_reg[LEVELS-1] || !out_stall;
    assign in_stall = !advance;

    genvar i;
    generate
        for (i = 0; i < LEVELS; i++)
        begin : g_level
            localparam sum_t SPAN = sum_t'(1) << (3 * (LEVELS - i));

            logic    v_in;
            icoord_t x_in, y_in, z_in;
            sum_t    s_in;
            logic    n_in;

            icoord_t z_m, x_t, y_t, z_t;
            sum_t    s_m, add, s_next;
            logic    n_next;
            quad_t   q;
            icoord_t x_next, y_next, z_next;

            // stage input: ports for the first level, previous stage otherwise
            if (i == 0)
            begin : g_first
                assign v_in = in_valid;
                assign x_in = icoord_t'(coord_x);
                assign y_in = icoord_t'(coord_y);
                assign z_in = icoord_t'(coord_z);
                assign s_in = '0;
                assign n_in = 1'b0;
            end
            else
            begin : g_rest
                assign v_in = valid_reg[i-1];
                assign x_in = x_reg[i-1];
                assign y_in = y_reg[i-1];
                assign z_in = z_reg[i-1];
                assign s_in = sum_reg[i-1];
                assign n_in = neg_reg[i-1];
            end

            // one refinement level
            always_comb
            begin
                // mirror positive z, add the span with the running sign
                if (z_in > 0)
                begin
                    z_m    = -z_in;
                    s_m    = n_in ? s_in - SPAN : s_in + SPAN;
                    n_next = !n_in;
                end
                else
                begin
                    z_m    = z_in;
                    s_m    = s_in;
                    n_next = n_in;
                end

                // quadrant offset in eighths of the span
                q      = quadrant(x_in, y_in);
                add    = {{(SUM_W-2){1'b0}}, q} << (3 * (LEVELS - i - 1));
                s_next = n_next ? s_m - add : s_m + add;

                x_t = translate(x_in);
                y_t = translate(y_in);
                z_t = translate(z_m);

                // fixed axis rotations chosen by quadrant
                case (q)
                    QUAD_PP:
                    begin
                        x_next = -z_t;
                        y_next = x_t;
                        z_next = -y_t;
                    end
                    QUAD_NP:
                    begin
                        x_next = -x_t;
                        y_next = -y_t;
                        z_next = z_t;
                    end
                    default:
                    begin
                        x_next = y_t;
                        y_next = -z_t;
                        z_next = -x_t;
                    end
                endcase
            end

            // stage valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[i] <= 1'b0;
                else if (advance)
                    valid_reg[i] <= v_in;
            end

            // stage payload
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    x_reg[i]   <= x_next;
                    y_reg[i]   <= y_next;
                    z_reg[i]   <= z_next;
                    sum_reg[i] <= s_next;
                    neg_reg[i] <= n_next;
                end
            end
        end
    endgenerate

    // last stage is the output register
    assign out_valid   = valid_reg[LEVELS-1];
    assign curve_index = sum_reg[LEVELS-1];

endmodule

>>> bench/tb.sv
// tb: self-checking bench for the hilbert_index_3d pipeline
// depends on hi3d_pkg (coordinate and quadrant types) and hilbert_index_3d

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hi3d_pkg::*;

    localparam int LEVELS = 15;
    localparam int IDX_W  = 3 * LEVELS + 1;
    localparam int MAX_REPORTS = 10;
    localparam int FOLD_ONE = 32768;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    coord_t           coord_x = '0;
    coord_t           coord_y = '0;
    coord_t           coord_z = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [IDX_W-1:0] curve_index;

    // expected curve positions, oldest first
    logic [IDX_W-1:0] expected_index[$];
    int mismatch_count = 0;
    int idle_pct = 11;
    int stall_pct = 11;

    hilbert_index_3d #(
        .LEVELS(LEVELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .coord_x(coord_x),
        .coord_y(coord_y),
        .coord_z(coord_z),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .curve_index(curve_index)
    );

    always #5 clk = ~clk;

    // halve-and-double on one axis, zero counts as non-negative
    function automatic icoord_t halve_double(input icoord_t p);
        int v;
        v = p;
        return icoord_t'((v >= 0) ? (2 * v - FOLD_ONE) : (2 * v + FOLD_ONE));
    endfunction

    // curve position of one point, one pass of the loop per level
    function automatic logic [IDX_W-1:0] hilbert_position(input coord_t cx, input coord_t cy,
                                                          input coord_t cz);
        icoord_t px, py, pz, ox, oy, oz;
        logic [63:0] acc, span, step;
        bit flipped;
        quad_t q;
        px = cx;
        py = cy;
        pz = cz;
        acc = '0;
        flipped = 1'b0;
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            span = 64'd1 << (3 * (LEVELS - lvl));
            step = span >> 3;
            // mirror a positive z and flip the running sign
            if (pz > 0)
            begin
                acc = flipped ? acc - span : acc + span;
                flipped = !flipped;
                pz = -pz;
            end
            // quadrant offset in eighths of the span
            if (px >= 0)
                q = (py >= 0) ? QUAD_PP : QUAD_PN;
            else
                q = (py < 0) ? QUAD_NN : QUAD_NP;
            acc = flipped ? acc - step * 64'(q) : acc + step * 64'(q);
            ox = halve_double(px);
            oy = halve_double(py);
            oz = halve_double(pz);
            // the two fixed turns, folded into one permutation per quadrant
            case (q)
                QUAD_PP:
                begin
                    px = -oz;
                    py = ox;
                    pz = -oy;
                end
                QUAD_NP:
                begin
                    px = -ox;
                    py = -oy;
                    pz = oz;
                end
                default:
                begin
                    px = oy;
                    py = -oz;
                    pz = -ox;
                end
            endcase
        end
        return acc[IDX_W-1:0];
    endfunction

    // mostly full-range patterns, now and then an edge value
    function automatic coord_t random_coord();
        coord_t edges[7] = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff,
                             16'sd16384, -16'sd16384};
        if ($urandom_range(7) == 0)
            return edges[$urandom_range(6)];
        return coord_t'($urandom);
    endfunction

    // present one item, hold it until accepted, then queue its expected position
    task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        coord_x  <= x;
        coord_y  <= y;
        coord_z  <= z;
        do
            @(posedge clk);
        while (in_stall);
        expected_index = {expected_index, hilbert_position(x, y, z)};
    endtask

    task automatic note_mismatch(input string what, input logic [IDX_W-1:0] want,
                                 input logic [IDX_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s curve_index expected %h actual %h", $realtime, what, want, got);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_index.size() == 0)
                note_mismatch("unexpected", '0, curve_index);
            else if (curve_index !== expected_index[0])
                note_mismatch("wrong", expected_index.pop_front(), curve_index);
            else
                void'(expected_index.pop_front());
        end
    end

    // output back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // four corners of the coordinate cube, plus the unit points either side of zero
    task automatic test_extremes();
        send_point(16'sh8000, 16'sh8000, 16'sh8000);
        send_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_point(16'sh8000, 16'sh7fff, 16'sh8000);
        send_point(16'sh7fff, 16'sh8000, 16'sh7fff);
        send_point(-16'sd1, -16'sd1, -16'sd1);
        send_point(16'sd1, 16'sd1, 16'sd1);
    endtask

    // zeros, z at the mirror threshold, points that fold onto zero
    task automatic test_zero_and_sign();
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd0, 16'sd0, 16'sd1);
        send_point(16'sd0, 16'sd0, -16'sd1);
        send_point(16'sd0, -16'sd1, 16'sd0);
        send_point(-16'sd1, 16'sd0, 16'sd0);
        send_point(16'sd16384, 16'sd16384, -16'sd16384);
        send_point(-16'sd16384, -16'sd16384, 16'sd16384);
    endtask

    // each x,y quadrant with z on both sides
    task automatic test_quadrants();
        send_point(16'sd1000, 16'sd2000, -16'sd300);
        send_point(16'sd1000, -16'sd2000, -16'sd300);
        send_point(-16'sd1000, -16'sd2000, -16'sd300);
        send_point(-16'sd1000, 16'sd2000, -16'sd300);
        send_point(16'sd20000, 16'sd9000, 16'sd300);
        send_point(16'sd20000, -16'sd9000, 16'sd300);
        send_point(-16'sd20000, -16'sd9000, 16'sd300);
        send_point(-16'sd20000, 16'sd9000, 16'sd300);
    endtask

    // random points with idling on both sides
    task automatic test_random_points(input int count);
        idle_pct  = 11;
        stall_pct = 11;
        repeat (count)
            send_point(random_coord(), random_coord(), random_coord());
    endtask

    // back-to-back items with no idling at all
    task automatic test_streaming(input int count);
        idle_pct  = 0;
        stall_pct = 0;
        repeat (count)
            send_point(random_coord(), random_coord(), random_coord());
        idle_pct  = 11;
        stall_pct = 11;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_zero_and_sign();
        test_quadrants();
        test_random_points(250);
        test_streaming(150);
        test_random_points(150);
        in_valid <= 1'b0;
        // drain the pipeline
        while (expected_index.size() != 0)
            @(posedge clk);
        repeat (LEVELS + 5) @(posedge clk);
        if (mismatch_count == 0 && expected_index.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
